FILE: hdl/fpsc_pkg.sv
package fpsc_pkg;

    localparam int DIV_W = 22;
    localparam int REM_W = 15;
    localparam int LEN_W = 5;

    localparam logic [6:0]       SCALE_MUL = 7'd95;
    localparam logic [REM_W-1:0] SCALE_DIV = 15'd23000;

    localparam logic [LEN_W-1:0] LEN_SCALE = 5'd22;
    localparam logic [LEN_W-1:0] LEN_ACC   = 5'd17;
    localparam logic [LEN_W-1:0] LEN_SAMP  = 5'd16;
    localparam logic [LEN_W-1:0] LEN_GAIN  = 5'd9;

    localparam logic signed [18:0] ACC_MAX = 19'sd65535;
    localparam logic signed [18:0] ACC_MIN = -19'sd65536;

    localparam logic [7:0]  RST_TARGET_LIMIT = 8'd120;
    localparam logic [11:0] RST_FAN_LIMIT    = 12'd1000;
    localparam logic [7:0]  RST_GAIN_DIV     = 8'd7;
    localparam logic [7:0]  RST_MANUAL_STEP  = 8'd10;
    localparam logic [7:0]  RST_AVG_DIV      = 8'd10;
    localparam logic [7:0]  RST_TARGET       = 8'd120;

    localparam logic [2:0] REG_TARGET_LIMIT = 3'd0;
    localparam logic [2:0] REG_FAN_LIMIT    = 3'd1;
    localparam logic [2:0] REG_GAIN_DIV     = 3'd2;
    localparam logic [2:0] REG_MANUAL_STEP  = 3'd3;
    localparam logic [2:0] REG_AVG_DIV      = 3'd4;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_DEBUG  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_AVG_A,
        S_AVG_B,
        S_STEP,
        S_GAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/fpsc_if.sv
interface fpsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_pressure;
    logic        mode_press;
    logic        down_press;
    logic        up_press;

    modport source (output valid, raw_pressure, mode_press, down_press, up_press,
                    input ready);
    modport sink (input valid, raw_pressure, mode_press, down_press, up_press,
                  output ready);
endinterface

interface fpsc_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        fan_drive;
    logic [7:0]         target_now;
    logic [1:0]         mode_now;
    logic signed [8:0]  pressure_pa;
    logic signed [16:0] average_q8;

    modport source (output valid, fan_drive, target_now, mode_now, pressure_pa, average_q8,
                    input ready);
    modport sink (input valid, fan_drive, target_now, mode_now, pressure_pa, average_q8,
                  output ready);
endinterface

interface fpsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/fpsc_div.sv
module fpsc_div
    import fpsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_divisor;
    logic [LEN_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_divisor};
    assign diff  = trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= i_req.len;
            end else if (r_run) begin
                r_cnt <= r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/fan_pressure_step_controller.sv
// Each item runs its divisions in turn on the shared serial divider, which
// yields one quotient bit per cycle; automatic mode adds a gain division. A new
// item is taken once the previous result sits in the output register.
// Reset (synchronous, active low) loads register defaults, debug mode,
// target 120, fan 0 and an unseeded average; no clearing pass.
module fan_pressure_step_controller
    import fpsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpsc_in_if.sink     i_in,
    fpsc_cfg_if.sink    i_cfg,
    fpsc_out_if.source  o_out
);

    logic [7:0]  r_target_limit;
    logic [11:0] r_fan_limit;
    logic [7:0]  r_gain_div;
    logic [7:0]  r_manual_step;
    logic [7:0]  r_avg_div;

    t_state             r_state;
    t_state             n_state;
    t_mode              r_mode;
    logic [7:0]         r_target;
    logic [11:0]        r_fan;
    logic signed [16:0] r_acc;
    logic               r_seeded;

    logic               r_neg_raw;
    logic               r_down;
    logic               r_up;
    logic signed [8:0]  r_p;
    logic signed [16:0] r_acc_cur;
    logic [16:0]        r_q1;
    logic signed [9:0]  r_delta;

    logic               r_out_valid;
    logic [11:0]        r_out_fan;
    logic [7:0]         r_out_target;
    logic [1:0]         r_out_mode;
    logic signed [8:0]  r_out_p;
    logic signed [16:0] r_out_acc;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic in_acc;
    logic cfg_acc;
    logic out_load;

    logic [15:0]        raw_mag;
    logic [21:0]        scaled_prod;
    logic [8:0]         p_pos;
    logic signed [8:0]  p_now;
    logic signed [16:0] acc_cur;
    logic [16:0]        acc_mag;
    logic [8:0]         p_abs;
    logic [18:0]        q1_ext;
    logic [18:0]        q2_ext;
    logic [18:0]        q1_term;
    logic [18:0]        q2_term;
    logic signed [18:0] acc_sum;
    logic signed [16:0] acc_new;
    logic signed [9:0]  t_step;
    logic [7:0]         target_new;
    logic signed [9:0]  delta_now;
    logic [9:0]         delta_neg;
    logic [8:0]         delta_mag;
    logic [8:0]         q_gain;
    logic signed [9:0]  change;
    logic signed [13:0] fan_auto;
    logic [11:0]        fan_auto_lim;
    logic [13:0]        step_ext;
    logic signed [13:0] fan_man;
    logic [7:0]         avg_d;
    logic [7:0]         gain_d;

    function automatic logic [11:0] fan_clamp(input logic signed [13:0] v,
                                              input logic [11:0] lim);
        logic [11:0] res;
        if (v < 14'sd0) begin
            res = '0;
        end else if (v > $signed({2'b00, lim})) begin
            res = lim;
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

    function automatic t_mode mode_next(input t_mode m);
        t_mode res;
        case (m)
            MODE_MANUAL: res = MODE_AUTO;
            MODE_AUTO:   res = MODE_DEBUG;
            default:     res = MODE_MANUAL;
        endcase
        return res;
    endfunction

    fpsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign avg_d  = (r_avg_div == 8'd0) ? 8'd1 : r_avg_div;
    assign gain_d = (r_gain_div == 8'd0) ? 8'd1 : r_gain_div;

    assign raw_mag     = i_in.raw_pressure[15] ? (~i_in.raw_pressure + 16'd1)
                                               : i_in.raw_pressure;
    assign scaled_prod = 22'(raw_mag) * 22'(SCALE_MUL);

    assign p_pos   = {1'b0, div_rsp.quotient[7:0]};
    assign p_now   = r_neg_raw ? (~p_pos + 9'd1) : p_pos;
    assign acc_cur = r_seeded ? r_acc : {p_now, 8'h00};
    assign acc_mag = acc_cur[16] ? (~acc_cur + 17'd1) : acc_cur;
    assign p_abs   = r_p[8] ? (~r_p + 9'd1) : r_p;

    assign q1_ext  = {2'b00, r_q1};
    assign q2_ext  = {3'b000, div_rsp.quotient[15:0]};
    assign q1_term = r_acc_cur[16] ? (~q1_ext + 19'd1) : q1_ext;
    assign q2_term = r_p[8] ? (~q2_ext + 19'd1) : q2_ext;
    assign acc_sum = {{2{r_acc_cur[16]}}, r_acc_cur} - q1_term + q2_term;

    always_comb begin
        if (acc_sum > ACC_MAX) begin
            acc_new = ACC_MAX[16:0];
        end else if (acc_sum < ACC_MIN) begin
            acc_new = ACC_MIN[16:0];
        end else begin
            acc_new = acc_sum[16:0];
        end
    end

    assign t_step = {2'b00, r_target} - {9'd0, r_down} + {9'd0, r_up};

    always_comb begin
        if (t_step < 10'sd0) begin
            target_new = '0;
        end else if (t_step > $signed({2'b00, r_target_limit})) begin
            target_new = r_target_limit;
        end else begin
            target_new = t_step[7:0];
        end
    end

    assign delta_now = {2'b00, target_new} - {r_p[8], r_p};
    assign delta_neg = -delta_now;
    assign delta_mag = delta_now[9] ? delta_neg[8:0] : delta_now[8:0];

    assign q_gain = div_rsp.quotient[8:0];

    always_comb begin
        if (q_gain == 9'd0) begin
            if (r_delta == 10'sd0) begin
                change = 10'sd0;
            end else if (r_delta[9]) begin
                change = -10'sd1;
            end else begin
                change = 10'sd1;
            end
        end else if (r_delta[9]) begin
            change = ~{1'b0, q_gain} + 10'd1;
        end else begin
            change = {1'b0, q_gain};
        end
    end

    assign fan_auto     = {2'b00, r_fan} + {{4{change[9]}}, change};
    assign fan_auto_lim = (r_target == 8'd0) ? 12'd0 : fan_clamp(fan_auto, r_fan_limit);

    assign step_ext = {6'd0, r_manual_step};
    assign fan_man  = {2'b00, r_fan} - (r_down ? step_ext : 14'd0)
                                     + (r_up ? step_ext : 14'd0);

    always_comb begin
        n_state = r_state;
        div_req = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state          = S_SCALE;
                    div_req.start    = 1'b1;
                    div_req.len      = LEN_SCALE;
                    div_req.dividend = scaled_prod;
                    div_req.divisor  = SCALE_DIV;
                end
            end
            S_SCALE: begin
                if (div_rsp.done) begin
                    n_state          = S_AVG_A;
                    div_req.start    = 1'b1;
                    div_req.len      = LEN_ACC;
                    div_req.dividend = {acc_mag, 5'd0};
                    div_req.divisor  = {7'd0, avg_d};
                end
            end
            S_AVG_A: begin
                if (div_rsp.done) begin
                    n_state          = S_AVG_B;
                    div_req.start    = 1'b1;
                    div_req.len      = LEN_SAMP;
                    div_req.dividend = {p_abs[7:0], 14'd0};
                    div_req.divisor  = {7'd0, avg_d};
                end
            end
            S_AVG_B: begin
                if (div_rsp.done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_mode == MODE_AUTO) begin
                    n_state          = S_GAIN;
                    div_req.start    = 1'b1;
                    div_req.len      = LEN_GAIN;
                    div_req.dividend = {delta_mag, 13'd0};
                    div_req.divisor  = {7'd0, gain_d};
                end else begin
                    n_state = S_FIN;
                end
            end
            S_GAIN: begin
                if (div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_target_limit <= RST_TARGET_LIMIT;
            r_fan_limit    <= RST_FAN_LIMIT;
            r_gain_div     <= RST_GAIN_DIV;
            r_manual_step  <= RST_MANUAL_STEP;
            r_avg_div      <= RST_AVG_DIV;
            r_mode         <= MODE_DEBUG;
            r_target       <= RST_TARGET;
            r_fan          <= '0;
            r_acc          <= '0;
            r_seeded       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg.index)
                    REG_TARGET_LIMIT: r_target_limit <= i_cfg.data[7:0];
                    REG_FAN_LIMIT:    r_fan_limit    <= i_cfg.data;
                    REG_GAIN_DIV:     r_gain_div     <= i_cfg.data[7:0];
                    REG_MANUAL_STEP:  r_manual_step  <= i_cfg.data[7:0];
                    REG_AVG_DIV:      r_avg_div      <= i_cfg.data[7:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc && i_in.mode_press) begin
                r_mode <= mode_next(r_mode);
            end
            if (r_state == S_AVG_B && div_rsp.done) begin
                r_acc    <= acc_new;
                r_seeded <= 1'b1;
            end
            if (r_state == S_STEP) begin
                case (r_mode)
                    MODE_AUTO:   r_target <= target_new;
                    MODE_MANUAL: r_fan    <= fan_clamp(fan_man, r_fan_limit);
                    default: begin
                    end
                endcase
            end
            if (r_state == S_GAIN && div_rsp.done) begin
                r_fan <= fan_auto_lim;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg_raw <= i_in.raw_pressure[15];
            r_down    <= i_in.down_press;
            r_up      <= i_in.up_press;
        end
        if (r_state == S_SCALE && div_rsp.done) begin
            r_p       <= p_now;
            r_acc_cur <= acc_cur;
        end
        if (r_state == S_AVG_A && div_rsp.done) begin
            r_q1 <= div_rsp.quotient[16:0];
        end
        if (r_state == S_STEP) begin
            r_delta <= delta_now;
        end
        if (out_load) begin
            r_out_fan    <= r_fan;
            r_out_target <= r_target;
            r_out_mode   <= r_mode;
            r_out_p      <= r_p;
            r_out_acc    <= r_acc;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fan_drive   = r_out_fan;
    assign o_out.target_now  = r_out_target;
    assign o_out.mode_now    = r_out_mode;
    assign o_out.pressure_pa = r_out_p;
    assign o_out.average_q8  = r_out_acc;

`ifndef SYNTHESIS
    a_accept_starts_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCALE))
        else $error("item accepted without starting the scale division");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_SCALE || r_state == S_AVG_A ||
                          r_state == S_AVG_B || r_state == S_GAIN))
        else $error("divider finished outside a waiting state");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the finish state");

    a_seed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded |=> r_seeded)
        else $error("average seed flag dropped");
`endif

endmodule

FILE: sim/fan_pressure_step_controller_test.sv
module fan_pressure_step_controller_test
    import fpsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 100;
    localparam int LONG_HOLD   = 600;

    typedef struct packed {
        logic [15:0] raw;
        logic        mode_press;
        logic        down_press;
        logic        up_press;
    } t_tick;

    typedef struct packed {
        logic [11:0]        fan_drive;
        logic [7:0]         target_now;
        t_mode              mode_now;
        logic signed [8:0]  pressure_pa;
        logic signed [16:0] average_q8;
    } t_fan_status;

    logic i_clk;
    logic i_rst_n;

    fpsc_in_if  in_if ();
    fpsc_cfg_if cfg_if ();
    fpsc_out_if out_if ();

    fan_pressure_step_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // controller state as predicted
    logic [7:0]  lim_target  = RST_TARGET_LIMIT;
    logic [11:0] lim_fan     = RST_FAN_LIMIT;
    logic [7:0]  gain_div    = RST_GAIN_DIV;
    logic [7:0]  step_manual = RST_MANUAL_STEP;
    logic [7:0]  avg_div     = RST_AVG_DIV;
    int          fan_lvl     = 0;
    int          tgt_lvl     = int'(RST_TARGET);
    t_mode       ctl_mode    = MODE_DEBUG;
    int          avg_acc     = 0;
    bit          avg_seeded  = 1'b0;

    t_fan_status expected_status[$];
    int          error_count   = 0;
    int          ticks_sent    = 0;
    int          results_seen  = 0;
    int          reg_writes    = 0;
    int          mode_hits[3]  = '{0, 0, 0};
    bit          no_idle       = 1'b0;
    int          hold_request  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int limit_to(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_fan_status advance_controller(t_tick t);
        int s, mag, p, d, g, delta, change;
        t_fan_status r;
        s = int'($signed(t.raw));
        mag = (s < 0) ? -s : s;
        mag = (mag * 95) / 23000;
        p = (s < 0) ? -mag : mag;
        if (t.mode_press) begin
            case (ctl_mode)
                MODE_MANUAL: ctl_mode = MODE_AUTO;
                MODE_AUTO:   ctl_mode = MODE_DEBUG;
                default:     ctl_mode = MODE_MANUAL;
            endcase
        end
        if (!avg_seeded) begin
            avg_acc = p * 256;
            avg_seeded = 1'b1;
        end
        d = (avg_div == 0) ? 1 : int'(avg_div);
        avg_acc = avg_acc - avg_acc / d + (p * 256) / d;
        avg_acc = limit_to(avg_acc, -65536, 65535);
        if (ctl_mode == MODE_AUTO) begin
            g = (gain_div == 0) ? 1 : int'(gain_div);
            if (t.down_press) tgt_lvl -= 1;
            if (t.up_press) tgt_lvl += 1;
            tgt_lvl = limit_to(tgt_lvl, 0, int'(lim_target));
            delta = tgt_lvl - p;
            change = delta / g;
            if (change == 0 && delta != 0) change = (delta < 0) ? -1 : 1;
            fan_lvl += change;
            if (tgt_lvl <= 0) fan_lvl = 0;
            fan_lvl = limit_to(fan_lvl, 0, int'(lim_fan));
        end else if (ctl_mode == MODE_MANUAL) begin
            if (t.down_press) fan_lvl -= int'(step_manual);
            if (t.up_press) fan_lvl += int'(step_manual);
            fan_lvl = limit_to(fan_lvl, 0, int'(lim_fan));
        end
        r.fan_drive   = fan_lvl[11:0];
        r.target_now  = tgt_lvl[7:0];
        r.mode_now    = ctl_mode;
        r.pressure_pa = p[8:0];
        r.average_q8  = avg_acc[16:0];
        return r;
    endfunction

    task automatic report_error(string what);
        $display("ERROR: result %0d: %s", results_seen, what);
        error_count++;
    endtask

    function automatic t_tick make_tick(logic [15:0] raw, bit m, bit dn, bit up);
        t_tick t;
        t.raw = raw;
        t.mode_press = m;
        t.down_press = dn;
        t.up_press = up;
        return t;
    endfunction

    // valid is left high after acceptance; the next item or a drain decides
    task automatic send_tick(t_tick t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.raw_pressure <= t.raw;
        in_if.mode_press   <= t.mode_press;
        in_if.down_press   <= t.down_press;
        in_if.up_press     <= t.up_press;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        expected_status.push_back(advance_controller(t));
        ticks_sent++;
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            REG_TARGET_LIMIT: lim_target  = value[7:0];
            REG_FAN_LIMIT:    lim_fan     = value;
            REG_GAIN_DIV:     gain_div    = value[7:0];
            REG_MANUAL_STEP:  step_manual = value[7:0];
            REG_AVG_DIV:      avg_div     = value[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(logic [7:0] tl, logic [11:0] fl, logic [7:0] gd,
                                logic [7:0] ms, logic [7:0] ad);
        wait_for_results();
        write_reg(REG_TARGET_LIMIT, {4'd0, tl});
        write_reg(REG_FAN_LIMIT, fl);
        write_reg(REG_GAIN_DIV, {4'd0, gd});
        write_reg(REG_MANUAL_STEP, {4'd0, ms});
        write_reg(REG_AVG_DIV, {4'd0, ad});
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [11:0] pick_fan_limit();
        case ($urandom_range(0, 4))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(0, 300));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic t_tick rand_tick();
        t_tick t;
        int mag;
        case ($urandom_range(0, 3))
            0: t.raw = 16'($urandom);
            1: begin
                mag = $urandom_range(0, 4000);
                t.raw = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: t.raw = 16'h0000;
                    1: t.raw = 16'h7FFF;
                    2: t.raw = 16'h8000;
                    default: t.raw = 16'hFFFF;
                endcase
                t.raw ^= 16'($urandom_range(0, 15));
            end
            // land near the target so the error stays small
            default: t.raw = 16'(tgt_lvl * 242 + $urandom_range(0, 1000) - 500);
        endcase
        t.mode_press = ($urandom_range(0, 9) == 0);
        t.down_press = 1'($urandom_range(0, 1));
        t.up_press   = 1'($urandom_range(0, 1));
        return t;
    endfunction

    task automatic test_sensor_extremes();
        send_tick(make_tick(16'h0000, 0, 0, 0));
        send_tick(make_tick(16'h7FFF, 0, 0, 0));
        send_tick(make_tick(16'h8000, 0, 0, 0));
        send_tick(make_tick(16'hFFFF, 0, 1, 1));
        send_tick(make_tick(16'h0001, 0, 0, 1));
        send_tick(make_tick(16'h00F3, 0, 1, 0));
        send_tick(make_tick(16'hFF0E, 0, 0, 0));
    endtask

    task automatic test_manual_mode();
        send_tick(make_tick(16'h1000, 1, 0, 1));
        send_tick(make_tick(16'h2000, 0, 0, 1));
        send_tick(make_tick(16'hE000, 0, 1, 1));
        send_tick(make_tick(16'h0100, 0, 1, 0));
        send_tick(make_tick(16'h0200, 0, 1, 0));
        send_tick(make_tick(16'h0300, 0, 1, 0));
        send_tick(make_tick(16'h0400, 0, 0, 0));
    endtask

    task automatic test_auto_mode();
        send_tick(make_tick(16'd28570, 1, 0, 0));
        send_tick(make_tick(16'h0000, 0, 0, 1));
        send_tick(make_tick(16'h8000, 0, 1, 0));
        send_tick(make_tick(16'h4000, 0, 1, 1));
        send_tick(make_tick(16'h7FFF, 0, 0, 0));
        send_tick(make_tick(16'd29540, 0, 0, 0));
        apply_config(8'd0, RST_FAN_LIMIT, RST_GAIN_DIV, RST_MANUAL_STEP, RST_AVG_DIV);
        send_tick(make_tick(16'hC000, 0, 0, 0));
        send_tick(make_tick(16'h8000, 0, 0, 1));
    endtask

    task automatic test_random_configs();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_config(8'd0, 12'd0, 8'd0, 8'd0, 8'd0);
                1: apply_config(8'd255, 12'd4095, 8'd255, 8'd255, 8'd255);
                2: apply_config(8'd255, 12'd4095, 8'd1, 8'd255, 8'd1);
                3: apply_config(RST_TARGET_LIMIT, RST_FAN_LIMIT, RST_GAIN_DIV,
                                RST_MANUAL_STEP, RST_AVG_DIV);
                default: apply_config(pick_byte(), pick_fan_limit(), pick_byte(),
                                      pick_byte(), pick_byte());
            endcase
            repeat (185) send_tick(rand_tick());
        end
    endtask

    task automatic test_streaming();
        no_idle = 1'b1;
        repeat (120) send_tick(rand_tick());
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        wait_for_results();
        hold_request = LONG_HOLD;
        no_idle = 1'b1;
        repeat (20) send_tick(rand_tick());
        no_idle = 1'b0;
        wait_for_results();
    endtask

    initial begin
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            t_fan_status want;
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            results_seen++;
            if (expected_status.size() == 0) begin
                report_error("result with nothing expected");
            end else begin
                want = expected_status.pop_front();
                if (want.mode_now <= MODE_DEBUG) mode_hits[want.mode_now]++;
                if (out_if.fan_drive !== want.fan_drive)
                    report_error($sformatf("fan_drive %0d, expected %0d",
                                           out_if.fan_drive, want.fan_drive));
                if (out_if.target_now !== want.target_now)
                    report_error($sformatf("target_now %0d, expected %0d",
                                           out_if.target_now, want.target_now));
                if (out_if.mode_now !== want.mode_now)
                    report_error($sformatf("mode_now %0d, expected %0d",
                                           out_if.mode_now, want.mode_now));
                if (out_if.pressure_pa !== want.pressure_pa)
                    report_error($sformatf("pressure_pa %0d, expected %0d",
                                           out_if.pressure_pa, want.pressure_pa));
                if (out_if.average_q8 !== want.average_q8)
                    report_error($sformatf("average_q8 %0d, expected %0d",
                                           out_if.average_q8, want.average_q8));
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: %0d cycles without a handshake", quiet);
                $display("fan_pressure_step_controller_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.raw_pressure <= 16'h0000;
        in_if.mode_press   <= 1'b0;
        in_if.down_press   <= 1'b0;
        in_if.up_press     <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= REG_TARGET_LIMIT;
        cfg_if.data        <= 12'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_sensor_extremes();
        test_manual_mode();
        test_auto_mode();
        test_random_configs();
        test_streaming();
        test_backpressure();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_status.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_status.size()));

        $display({"%0d ticks checked after %0d register writes; ",
                  "manual %0d, automatic %0d, debug %0d"},
                 results_seen, reg_writes, mode_hits[0], mode_hits[1], mode_hits[2]);
        $display("errors: %0d", error_count);
        if (error_count == 0) begin
            $display("fan_pressure_step_controller_test: PASS");
        end else begin
            $display("fan_pressure_step_controller_test: FAIL");
        end
        $finish;
    end

endmodule
